// ===== src/s2l_pkg.sv =====
// Shared types, constants and the sRGB linearization table for the sRGB to CIELAB converter.
package s2l_pkg;

    // Port widths fixed by the item format.
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int XYZ_W         = 15;
    localparam int LAB_OUT_W     = 16;
    localparam int FRAC_BITS_DEF = 8;

    // Internal number formats.
    localparam int LQ      = 30;            // linear channel is Q30
    localparam int LIN_W   = LQ + 1;
    localparam int COEF_W  = 14;
    localparam int SUM_W   = 44;            // matrix sums and ratio quotient
    localparam int DEN_W   = 21;            // 25 times a 16-bit white value
    localparam int FQ      = 24;            // ratio and segment are Q24
    localparam int CBRT_W  = 29;
    localparam int SQ_W    = 2 * CBRT_W;
    localparam int LAB_W   = 40;
    localparam int V_LIN_W = 18;
    localparam int LIN_X_W = 32;

    // Stages of one channel unit: numerator, divider bits, linear segment,
    // two stages per cube-root bit, and the final select.
    localparam int CHAN_LAT = 1 + SUM_W + 2 + 2 * CBRT_W + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_X = 2'd0,
        CFG_WHITE_Y = 2'd1,
        CFG_WHITE_Z = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] WHITE_X_RST = 16'd24332;
    localparam logic [CFG_W-1:0] WHITE_Y_RST = 16'd25600;
    localparam logic [CFG_W-1:0] WHITE_Z_RST = 16'd27874;

    // sRGB to XYZ matrix scaled by 10000, rows X, Y, Z.
    typedef logic [COEF_W-1:0] t_coef [3][3];
    localparam t_coef COEF = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    // Lab segment constants.
    localparam logic [SUM_W-1:0] V_THRESH =
        SUM_W'((64'd8856 << FQ) / 64'd1000000);
    localparam logic [LIN_X_W-1:0] LIN_SLOPE = 32'd7787;
    localparam logic [LIN_X_W-1:0] LIN_RND   = 32'd500;
    localparam int RECIP_1000_SH = 41;
    localparam logic [63:0] RECIP_1000 = ((64'd1 << RECIP_1000_SH) + 64'd999) / 64'd1000;
    localparam logic [63:0] LIN_OFFS   = ((64'd16 << FQ) + 64'd58) / 64'd116;

    // XYZ output scaling: divide by 100 via reciprocal once saturation is ruled out.
    localparam int XYZ_M_W       = 22;
    localparam int RECIP_100_SH  = 29;
    localparam logic [63:0] XYZ_RND    = 64'd50 << LQ;
    localparam logic [63:0] RECIP_100  = ((64'd1 << RECIP_100_SH) + 64'd99) / 64'd100;
    localparam logic [63:0] XYZ_SAT_M  = 64'd32768 * 64'd100;
    localparam logic [XYZ_W-1:0] XYZ_MAX = 15'h7FFF;

    typedef struct packed {
        logic [XYZ_W-1:0] x;
        logic [XYZ_W-1:0] y;
        logic [XYZ_W-1:0] z;
    } t_xyz;

    typedef struct packed {
        t_xyz                        xyz;
        logic signed [LAB_OUT_W-1:0] l;
        logic signed [LAB_OUT_W-1:0] a;
        logic signed [LAB_OUT_W-1:0] b;
    } t_result;

    // One entry of the gamma removal table, evaluated at elaboration.
    function automatic logic [LIN_W-1:0] lin_entry(input int unsigned c);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p;
        if (c <= 10) begin
            return LIN_W'(((64'(c) * 64'd10 << LQ) + 64'd16473) / 64'd32946);
        end
        t = ((64'(1000 * c + 14025) << LQ) + 64'd134512) / 64'd269025;
        u = (t * t) >> LQ;
        r = '0;
        for (int k = LQ - 1; k >= 0; k--) begin
            cand = r | (64'd1 << k);
            p = (cand * cand) >> LQ;
            p = (p * cand) >> LQ;
            p = (p * cand) >> LQ;
            p = (p * cand) >> LQ;
            if (p <= u) begin
                r = cand;
            end
        end
        if (u >= (64'd1 << LQ)) begin
            r = 64'd1 << LQ;
        end
        return LIN_W'((u * r) >> LQ);
    endfunction

    typedef logic [LIN_W-1:0] t_lin_tab [256];

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = lin_entry(i);
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

// ===== src/srgb_to_cielab.sv =====
// Top level of the sRGB to CIE XYZ and CIELAB pixel converter.
//
// Input channel: i_in_valid / o_in_ready carry one pixel (i_red, i_green,
// i_blue). Output channel: o_out_valid / i_out_ready carry X, Y, Z and L*, a*,
// b* in Q(FRAC_BITS). An item moves when valid and ready are both high.
// Configuration: i_cfg_we writes i_cfg_data to the white point register
// chosen by i_cfg_idx (X, Y, Z); unknown indexes are ignored. Write only
// while no item is in flight.
// Throughput: one item per clock while the output buffer has room. The pipeline
// length is set by the restoring white point divider (44 stages) and the cube
// root (two stages per bit). The pipeline advances as a whole and ends in a
// two-entry output buffer, so a pixel is still taken while one result waits;
// o_in_ready falls only when both buffer entries are full and rises again once
// the receiver takes one.
// Reset clears all valid bits and the buffer and loads the D65 white point.
module srgb_to_cielab #(
    parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [s2l_pkg::PIX_W-1:0]              i_red,
    input  logic [s2l_pkg::PIX_W-1:0]              i_green,
    input  logic [s2l_pkg::PIX_W-1:0]              i_blue,
    input  logic                                   i_cfg_we,
    input  logic [s2l_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [s2l_pkg::CFG_W-1:0]              i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [s2l_pkg::XYZ_W-1:0]              o_x_value,
    output logic [s2l_pkg::XYZ_W-1:0]              o_y_value,
    output logic [s2l_pkg::XYZ_W-1:0]              o_z_value,
    output logic signed [s2l_pkg::LAB_OUT_W-1:0]   o_lightness,
    output logic signed [s2l_pkg::LAB_OUT_W-1:0]   o_a_axis,
    output logic signed [s2l_pkg::LAB_OUT_W-1:0]   o_b_axis
);
    import s2l_pkg::*;

    localparam int NST  = CHAN_LAT + 4;
    localparam int XDLY = CHAN_LAT - 1;
    localparam int SH   = FQ - FRAC_BITS;

    localparam logic signed [LAB_W-1:0] K_L    = 40'sd116;
    localparam logic signed [LAB_W-1:0] K_A    = 40'sd500;
    localparam logic signed [LAB_W-1:0] K_B    = 40'sd200;
    localparam logic signed [LAB_W-1:0] L_OFFS = LAB_W'(64'd16 << FQ);

    // Round a Q24 value half away from zero to Q(FRAC_BITS) and saturate.
    function automatic logic signed [LAB_OUT_W-1:0] to_lab(
        input logic signed [LAB_W-1:0] v
    );
        logic [LAB_W-1:0] mag;
        logic [LAB_W-1:0] rnd;
        mag = v[LAB_W-1] ? LAB_W'(-v) : LAB_W'(v);
        rnd = (mag + (LAB_W'(1) << (SH - 1))) >> SH;
        if (!v[LAB_W-1]) begin
            return (rnd > LAB_W'(32767)) ? 16'sh7FFF : LAB_OUT_W'(rnd);
        end
        return (rnd > LAB_W'(32768)) ? 16'sh8000 : LAB_OUT_W'(-rnd);
    endfunction

    logic en;
    logic r_skid_vld;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;

    // White point registers and the divisors derived from them.
    logic [CFG_W-1:0] r_white [3];
    logic [DEN_W-1:0] r_den   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white[0] <= WHITE_X_RST;
            r_white[1] <= WHITE_Y_RST;
            r_white[2] <= WHITE_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WHITE_X: r_white[0] <= i_cfg_data;
                CFG_WHITE_Y: r_white[1] <= i_cfg_data;
                CFG_WHITE_Z: r_white[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_den[i] <= DEN_W'((r_white[i] == '0) ? CFG_W'(1) : r_white[i]) * DEN_W'(25);
        end
    end

    // Valid bits travel with the pipeline.
    logic [NST-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Gamma removal, matrix products and matrix sums.
    logic [LIN_W-1:0] r_lin  [3];
    logic [SUM_W-1:0] r_prod [3][3];
    logic [SUM_W-1:0] r_sum  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lin[0] <= LIN_TAB[i_red];
            r_lin[1] <= LIN_TAB[i_green];
            r_lin[2] <= LIN_TAB[i_blue];
            for (int row = 0; row < 3; row++) begin
                for (int col = 0; col < 3; col++) begin
                    r_prod[row][col] <= SUM_W'(r_lin[col]) * SUM_W'(COEF[row][col]);
                end
                r_sum[row] <= r_prod[row][0] + r_prod[row][1] + r_prod[row][2];
            end
        end
    end

    // XYZ outputs: scale, check saturation, divide by 100, then delay.
    logic [63:0]        xsh  [3];
    logic [33:0]        xm   [3];
    logic [63:0]        xq   [3];
    logic [XYZ_M_W-1:0] r_xm [3];
    logic               r_xsat [3];
    logic [XYZ_W-1:0]   r_xq [3];
    t_xyz               r_xdly [XDLY];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xsh[i] = (64'(r_sum[i]) << FRAC_BITS) + XYZ_RND;
            xm[i]  = xsh[i][63:LQ];
            xq[i]  = (64'(r_xm[i]) * RECIP_100) >> RECIP_100_SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_xm[i]   <= xm[i][XYZ_M_W-1:0];
                r_xsat[i] <= (64'(xm[i]) >= XYZ_SAT_M);
                r_xq[i]   <= r_xsat[i] ? XYZ_MAX : xq[i][XYZ_W-1:0];
            end
            r_xdly[0] <= '{x: r_xq[0], y: r_xq[1], z: r_xq[2]};
            for (int k = 1; k < XDLY; k++) begin
                r_xdly[k] <= r_xdly[k-1];
            end
        end
    end

    // Ratio to white and Lab segment, one unit per axis.
    logic [CBRT_W-1:0] f_val [3];

    for (genvar g = 0; g < 3; g++) begin : g_chan
        s2l_chan u_chan (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sum (r_sum[g]),
            .i_den (r_den[g]),
            .o_f   (f_val[g])
        );
    end

    // L, a and b in Q24.
    logic signed [LAB_W-1:0] fx_s;
    logic signed [LAB_W-1:0] fy_s;
    logic signed [LAB_W-1:0] fz_s;
    logic signed [LAB_W-1:0] r_lab_l;
    logic signed [LAB_W-1:0] r_lab_a;
    logic signed [LAB_W-1:0] r_lab_b;

    assign fx_s = $signed(LAB_W'(f_val[0]));
    assign fy_s = $signed(LAB_W'(f_val[1]));
    assign fz_s = $signed(LAB_W'(f_val[2]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lab_l <= fy_s * K_L - L_OFFS;
            r_lab_a <= (fx_s - fy_s) * K_A;
            r_lab_b <= (fy_s - fz_s) * K_B;
        end
    end

    // Two-entry output buffer; rounding of Lab happens on the way in.
    t_result new_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    push;
    logic    pop;

    assign new_res = '{xyz: r_xdly[XDLY-1], l: to_lab(r_lab_l),
                       a: to_lab(r_lab_a), b: to_lab(r_lab_b)};
    assign push    = en && r_vld[NST-1];
    assign pop     = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= push;
            end else begin
                r_out_vld  <= push;
            end
        end else if (push) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_vld) begin
            r_out <= r_skid;
        end else if (push && (!r_out_vld || pop)) begin
            r_out <= new_res;
        end
        if (push && r_out_vld && !pop) begin
            r_skid <= new_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_x_value   = r_out.xyz.x;
    assign o_y_value   = r_out.xyz.y;
    assign o_z_value   = r_out.xyz.z;
    assign o_lightness = r_out.l;
    assign o_a_axis    = r_out.a;
    assign o_b_axis    = r_out.b;

endmodule

// ===== src/s2l_chan.sv =====
// One channel of the Lab segment: pipelined divide by the white point, then cube root or linear.
module s2l_chan (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [s2l_pkg::SUM_W-1:0]    i_sum,
    input  logic [s2l_pkg::DEN_W-1:0]    i_den,
    output logic [s2l_pkg::CBRT_W-1:0]   o_f
);
    import s2l_pkg::*;

    localparam int PROD_W = SQ_W - FQ + CBRT_W;

    // Restoring divider, one quotient bit per stage. The numerator bits shift
    // out at the top while the quotient bits shift in at the bottom.
    logic [DEN_W-1:0] r_rem [SUM_W+1];
    logic [SUM_W-1:0] r_num [SUM_W+1];
    logic [DEN_W:0]   trial [SUM_W];
    logic             q_bit [SUM_W];

    always_comb begin
        for (int k = 0; k < SUM_W; k++) begin
            trial[k] = {r_rem[k], r_num[k][SUM_W-1]};
            q_bit[k] = (trial[k] >= {1'b0, i_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_sum + SUM_W'(i_den >> 1);
            for (int k = 0; k < SUM_W; k++) begin
                r_rem[k+1] <= q_bit[k] ? DEN_W'(trial[k] - {1'b0, i_den})
                                       : trial[k][DEN_W-1:0];
                r_num[k+1] <= {r_num[k][SUM_W-2:0], q_bit[k]};
            end
        end
    end

    // Linear segment, computed ahead of the cube root and carried along with it.
    logic [SUM_W-1:0]   r_e1_v;
    logic               r_e1_cube;
    logic [LIN_X_W-1:0] r_e1_x;
    logic [SUM_W-1:0]   r_e2_v;
    logic               r_e2_cube;
    logic [CBRT_W-1:0]  r_e2_linf;
    logic [63:0]        lin_prod;

    assign lin_prod = 64'(r_e1_x) * RECIP_1000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1_v    <= r_num[SUM_W];
            r_e1_cube <= (r_num[SUM_W] > V_THRESH);
            r_e1_x    <= LIN_X_W'(r_num[SUM_W][V_LIN_W-1:0]) * LIN_SLOPE + LIN_RND;
            r_e2_v    <= r_e1_v;
            r_e2_cube <= r_e1_cube;
            r_e2_linf <= CBRT_W'(lin_prod >> RECIP_1000_SH) + CBRT_W'(LIN_OFFS);
        end
    end

    // Cube root by bit search: the first stage of each bit builds the candidate
    // and its exact square by shifts and adds, the second cubes and compares.
    logic [CBRT_W-1:0] src_r    [CBRT_W];
    logic [SQ_W-1:0]   src_r2   [CBRT_W];
    logic [SUM_W-1:0]  src_v    [CBRT_W];
    logic              src_cube [CBRT_W];
    logic [CBRT_W-1:0] src_linf [CBRT_W];

    logic [CBRT_W-1:0] r_a_r    [CBRT_W];
    logic [SQ_W-1:0]   r_a_r2   [CBRT_W];
    logic [CBRT_W-1:0] r_a_c    [CBRT_W];
    logic [SQ_W-1:0]   r_a_c2   [CBRT_W];
    logic [SUM_W-1:0]  r_a_v    [CBRT_W];
    logic              r_a_cube [CBRT_W];
    logic [CBRT_W-1:0] r_a_linf [CBRT_W];

    logic [CBRT_W-1:0] r_b_r    [CBRT_W];
    logic [SQ_W-1:0]   r_b_r2   [CBRT_W];
    logic [SUM_W-1:0]  r_b_v    [CBRT_W];
    logic              r_b_cube [CBRT_W];
    logic [CBRT_W-1:0] r_b_linf [CBRT_W];

    logic [PROD_W-1:0] b_prod [CBRT_W];
    logic              b_ok   [CBRT_W];

    always_comb begin
        src_r[0]    = '0;
        src_r2[0]   = '0;
        src_v[0]    = r_e2_v;
        src_cube[0] = r_e2_cube;
        src_linf[0] = r_e2_linf;
        for (int j = 1; j < CBRT_W; j++) begin
            src_r[j]    = r_b_r[j-1];
            src_r2[j]   = r_b_r2[j-1];
            src_v[j]    = r_b_v[j-1];
            src_cube[j] = r_b_cube[j-1];
            src_linf[j] = r_b_linf[j-1];
        end
        for (int j = 0; j < CBRT_W; j++) begin
            b_prod[j] = PROD_W'(r_a_c2[j][SQ_W-1:FQ]) * PROD_W'(r_a_c[j]);
            b_ok[j]   = (SUM_W'(b_prod[j][PROD_W-1:FQ]) <= r_a_v[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < CBRT_W; j++) begin
                r_a_r[j]    <= src_r[j];
                r_a_r2[j]   <= src_r2[j];
                r_a_c[j]    <= src_r[j] | (CBRT_W'(1) << (CBRT_W - 1 - j));
                r_a_c2[j]   <= src_r2[j] + (SQ_W'(src_r[j]) << (CBRT_W - j))
                               + (SQ_W'(1) << (2 * (CBRT_W - 1 - j)));
                r_a_v[j]    <= src_v[j];
                r_a_cube[j] <= src_cube[j];
                r_a_linf[j] <= src_linf[j];

                r_b_r[j]    <= b_ok[j] ? r_a_c[j] : r_a_r[j];
                r_b_r2[j]   <= b_ok[j] ? r_a_c2[j] : r_a_r2[j];
                r_b_v[j]    <= r_a_v[j];
                r_b_cube[j] <= r_a_cube[j];
                r_b_linf[j] <= r_a_linf[j];
            end
        end
    end

    // Pick the segment.
    logic [CBRT_W-1:0] r_f;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f <= r_b_cube[CBRT_W-1] ? r_b_r[CBRT_W-1] : r_b_linf[CBRT_W-1];
        end
    end

    assign o_f = r_f;

endmodule

// ===== src/s2l_check.sv =====
// Port-level assertions for the sRGB to CIELAB converter, bound to the top level.
module s2l_check (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic [s2l_pkg::XYZ_W-1:0]             o_x_value,
    input logic signed [s2l_pkg::LAB_OUT_W-1:0]  o_lightness
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_x_value)
                                        && $stable(o_lightness))
        else $error("result changed while stalled");

    // Reset empties the output buffer and opens the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("buffer not empty after reset");

    // The input closes only with a result waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input blocked with no result waiting");

    // The input closes only after the receiver stalled a result.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input closed without a stall");

endmodule

bind srgb_to_cielab s2l_check u_s2l_check (.*);

// ===== tb/tb_srgb_to_cielab.sv =====
// Self-checking testbench for the sRGB to XYZ and CIELAB pixel converter.
`timescale 1ns / 100ps

module tb_srgb_to_cielab;
    import s2l_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int RESULT_LATENCY = 110;
    localparam longint CYCLE_LIMIT = 2000000;
    // Index three selects no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [PIX_W-1:0]            i_red;
    logic [PIX_W-1:0]            i_green;
    logic [PIX_W-1:0]            i_blue;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [XYZ_W-1:0]            o_x_value;
    logic [XYZ_W-1:0]            o_y_value;
    logic [XYZ_W-1:0]            o_z_value;
    logic signed [LAB_OUT_W-1:0] o_lightness;
    logic signed [LAB_OUT_W-1:0] o_a_axis;
    logic signed [LAB_OUT_W-1:0] o_b_axis;

    srgb_to_cielab #(.FRAC_BITS(FRAC)) dut (.*);

    // Pixels waiting to be sent and conversions waiting to come back.
    t_pixel  pixel_q[$];
    t_result color_q[$];
    logic [CFG_W-1:0] ref_white[3];
    bit     hold_input;
    bit     steady_mode;
    int     in_gap;
    int     out_gap;
    int     mismatches;
    longint cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Mostly short pauses, now and then a long one; none in steady mode.
    function automatic int pause_len();
        int pick;
        pick = $urandom_range(99);
        if (steady_mode || pick < 55) return 0;
        if (pick < 88) return $urandom_range(3, 1);
        if (pick < 98) return $urandom_range(15, 4);
        return $urandom_range(100, 30);
    endfunction

    // Gamma removal of one 8-bit channel into Q30 linear light.
    function automatic logic [63:0] srgb_decode(logic [7:0] code);
        logic [63:0] c;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] p;
        c = 64'(code);
        if (c <= 64'd10) return ((c * 64'd10 << 30) + 64'd16473) / 64'd32946;
        t = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        u = (t * t) >> 30;
        root = '0;
        // Fifth root of u, bit by bit, with truncated products.
        for (int k = 29; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            p = (cand * cand) >> 30;
            p = (p * cand) >> 30;
            p = (p * cand) >> 30;
            p = (p * cand) >> 30;
            if (p <= u) root = cand;
        end
        if (u >= (64'd1 << 30)) root = 64'd1 << 30;
        return (u * root) >> 30;
    endfunction

    // Ratio to the white point and the Lab cube-root or linear segment, Q24.
    function automatic longint lab_segment(logic [63:0] sum, logic [CFG_W-1:0] white);
        logic [63:0] den;
        logic [63:0] ratio;
        logic [63:0] root;
        logic [63:0] cand;
        den = 64'd25 * ((white == '0) ? 64'd1 : 64'(white));
        ratio = (sum + den / 2) / den;
        if (ratio * 64'd1000000 > (64'd8856 << 24)) begin
            root = '0;
            for (int k = 28; k >= 0; k--) begin
                cand = root | (64'd1 << k);
                if ((((cand * cand) >> 24) * cand) >> 24 <= ratio) root = cand;
            end
            return longint'(root);
        end
        return longint'((ratio * 64'd7787 + 64'd500) / 64'd1000
                        + ((64'd16 << 24) + 64'd58) / 64'd116);
    endfunction

    function automatic logic [XYZ_W-1:0] xyz_scale(logic [63:0] sum);
        logic [63:0] den;
        logic [63:0] q;
        den = 64'd100 << 30;
        q = ((sum << FRAC) + den / 2) / den;
        return (q > 64'd32767) ? XYZ_MAX : XYZ_W'(q);
    endfunction

    // Q24 to Q(FRAC), rounded half away from zero, then saturated.
    function automatic logic signed [LAB_OUT_W-1:0] lab_round(longint v);
        logic [63:0] mag;
        longint q;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (23 - FRAC))) >> (24 - FRAC);
        if (mag > 64'd40000) mag = 64'd40000;
        q = (v < 0) ? -longint'(mag) : longint'(mag);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return LAB_OUT_W'(q);
    endfunction

    function automatic t_result convert_pixel(t_pixel px);
        logic [63:0] lr;
        logic [63:0] lg;
        logic [63:0] lb;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        longint fx;
        longint fy;
        longint fz;
        t_result res;
        lr = srgb_decode(px.red);
        lg = srgb_decode(px.green);
        lb = srgb_decode(px.blue);
        sx = lr * 64'd4124 + lg * 64'd3576 + lb * 64'd1805;
        sy = lr * 64'd2126 + lg * 64'd7152 + lb * 64'd722;
        sz = lr * 64'd193 + lg * 64'd1192 + lb * 64'd9505;
        fx = lab_segment(sx, ref_white[CFG_WHITE_X]);
        fy = lab_segment(sy, ref_white[CFG_WHITE_Y]);
        fz = lab_segment(sz, ref_white[CFG_WHITE_Z]);
        res.xyz.x = xyz_scale(sx);
        res.xyz.y = xyz_scale(sy);
        res.xyz.z = xyz_scale(sz);
        res.l = lab_round(116 * fy - (longint'(16) << 24));
        res.a = lab_round(500 * (fx - fy));
        res.b = lab_round(200 * (fy - fz));
        return res;
    endfunction

    // Pixel driver: records each accepted item, then presents the next one.
    always @(posedge i_clk) begin
        t_pixel px;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                px = '{red: i_red, green: i_green, blue: i_blue};
                color_q.push_back(convert_pixel(px));
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0 && !hold_input) begin
                    px = pixel_q.pop_front();
                    i_red <= px.red;
                    i_green <= px.green;
                    i_blue <= px.blue;
                    i_in_valid <= 1'b1;
                    in_gap = pause_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (color_q.size() == 0) begin
                    $error("result with no pixel outstanding");
                    mismatches++;
                end else begin
                    exp_res = color_q.pop_front();
                    if (o_x_value !== exp_res.xyz.x) begin
                        $error("x_value: expected %0d, got %0d", exp_res.xyz.x, o_x_value);
                        mismatches++;
                    end
                    if (o_y_value !== exp_res.xyz.y) begin
                        $error("y_value: expected %0d, got %0d", exp_res.xyz.y, o_y_value);
                        mismatches++;
                    end
                    if (o_z_value !== exp_res.xyz.z) begin
                        $error("z_value: expected %0d, got %0d", exp_res.xyz.z, o_z_value);
                        mismatches++;
                    end
                    if (o_lightness !== exp_res.l) begin
                        $error("lightness: expected %0d, got %0d", exp_res.l, o_lightness);
                        mismatches++;
                    end
                    if (o_a_axis !== exp_res.a) begin
                        $error("a_axis: expected %0d, got %0d", exp_res.a, o_a_axis);
                        mismatches++;
                    end
                    if (o_b_axis !== exp_res.b) begin
                        $error("b_axis: expected %0d, got %0d", exp_res.b, o_b_axis);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(3) == 0) out_gap = pause_len();
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_srgb_to_cielab: errors");
            $finish;
        end
    end

    // Wait until no pixel is queued, in flight or unanswered.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_q.size() > 0 || i_in_valid || color_q.size() > 0);
    endtask

    task automatic write_white(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx != CFG_UNMAPPED) ref_white[idx] = value;
    endtask

    task automatic set_whites(logic [CFG_W-1:0] wx, logic [CFG_W-1:0] wy,
                              logic [CFG_W-1:0] wz);
        wait_idle();
        write_white(CFG_WHITE_X, wx);
        write_white(CFG_WHITE_Y, wy);
        write_white(CFG_WHITE_Z, wz);
    endtask

    task automatic add_pixel(int r, int g, int b);
        pixel_q.push_back('{red: PIX_W'(r), green: PIX_W'(g), blue: PIX_W'(b)});
    endtask

    // Random pixels; a share are dark to reach the linear segments.
    task automatic add_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(4) == 0)
                add_pixel($urandom_range(24), $urandom_range(24), $urandom_range(24));
            else
                add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WHITE_X;
        i_cfg_data = '0;
        i_out_ready = 1'b0;
        hold_input = 1'b0;
        steady_mode = 1'b0;
        in_gap = 0;
        out_gap = 0;
        mismatches = 0;
        cycles = 0;
        ref_white[CFG_WHITE_X] = WHITE_X_RST;
        ref_white[CFG_WHITE_Y] = WHITE_Y_RST;
        ref_white[CFG_WHITE_Z] = WHITE_Z_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at the reset white point: black, white, primaries, secondaries,
        // the gamma segment edge and single-channel extremes.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(10, 10, 10);
        add_pixel(11, 11, 11);
        add_pixel(10, 11, 12);
        add_pixel(1, 1, 1);
        add_pixel(1, 0, 0);
        add_pixel(0, 0, 1);
        add_pixel(128, 128, 128);
        add_pixel(170, 85, 42);
        add_pixel(85, 170, 213);
        add_pixel(254, 254, 254);
        add_pixel(3, 200, 7);

        // Let the pipeline drain once, then hold the sender for a while
        // with items queued.
        wait_idle();
        hold_input = 1'b1;
        add_random(300);
        repeat (RESULT_LATENCY) @(negedge i_clk);
        hold_input = 1'b0;

        // Smallest white points make the ratios large and push many Lab results into saturation.
        set_whites(16'd1, 16'd1, 16'd1);
        add_random(150);

        // Largest white points keep the ratios small.
        set_whites(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random(150);

        // A zero white value behaves as one; an unmapped write is ignored.
        set_whites(16'd0, 16'd25600, 16'd0);
        write_white(CFG_UNMAPPED, 16'hA5A5);
        add_random(150);

        // Random white points with no idling on either side.
        steady_mode = 1'b1;
        set_whites(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                   16'($urandom_range(65535, 1)));
        add_random(300);
        wait_idle();
        steady_mode = 1'b0;

        // Back to D65 for the rest.
        set_whites(WHITE_X_RST, WHITE_Y_RST, WHITE_Z_RST);
        add_random(550);

        wait_idle();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_srgb_to_cielab: clean");
        else
            $display("tb_srgb_to_cielab: errors");
        $finish;
    end

endmodule

// ===== srgb_to_cielab.f =====
src/s2l_pkg.sv
src/s2l_chan.sv
src/srgb_to_cielab.sv
src/s2l_check.sv
tb/tb_srgb_to_cielab.sv
